// ===== src/mtep_pkg.sv =====
// mtep_pkg: shared types and codes for the midi track event parser
// no dependencies; used by the parser, the output buffer, the top level and the checker

package mtep_pkg;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_STATUS = 2'd1;
   localparam logic [1:0] ERR_LONG   = 2'd2;

   typedef struct packed {
      logic [31:0] delta_ticks;
      logic [7:0]  status_byte;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
      logic [1:0]  parse_error;
   } mtep_result_type;

endpackage

// ===== src/mtep_parser.sv =====
// mtep_parser: track byte state machine, delta and meta length reader, time sum
// depends on mtep_pkg

module mtep_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               track_byte,
   output logic                     result_valid,
   output mtep_pkg::mtep_result_type result
);
   import mtep_pkg::*;

   localparam logic [2:0] PH_DELTA     = 3'd0;
   localparam logic [2:0] PH_STATUS    = 3'd1;
   localparam logic [2:0] PH_META_TYPE = 3'd2;
   localparam logic [2:0] PH_META_LEN  = 3'd3;
   localparam logic [2:0] PH_META_SKIP = 3'd4;
   localparam logic [2:0] PH_P1_OF_TWO = 3'd5;
   localparam logic [2:0] PH_P2        = 3'd6;
   localparam logic [2:0] PH_P1_ONLY   = 3'd7;

   localparam logic [7:0] META_STATUS = 8'hff;
   localparam logic [3:0] HI_NOTE_OFF = 4'h8;
   localparam logic [3:0] HI_NOTE_ON  = 4'h9;
   localparam logic [3:0] HI_POLY_AT  = 4'ha;
   localparam logic [3:0] HI_CONTROL  = 4'hb;
   localparam logic [3:0] HI_PROGRAM  = 4'hc;
   localparam logic [3:0] HI_CHAN_AT  = 4'hd;
   localparam logic [3:0] HI_BEND     = 4'he;
   localparam logic [1:0] VLV_LAST    = 2'd3;

   logic [2:0]  phase_ff, phase_in;
   logic [27:0] vlv_accum_ff, vlv_accum_in;
   logic [1:0]  vlv_count_ff, vlv_count_in;
   logic [31:0] time_accum_ff, time_accum_in;
   logic [7:0]  running_status_ff, running_status_in;
   logic [27:0] meta_remaining_ff, meta_remaining_in;
   logic [7:0]  held_first_param_ff, held_first_param_in;

   logic        is_data;
   logic [27:0] vlv_shift;
   logic [32:0] time_sum;
   logic [31:0] time_sat;
   logic [27:0] meta_dec;
   logic [7:0]  cmd;
   logic        emit;

   assign is_data   = ~track_byte[7];
   assign vlv_shift = {vlv_accum_ff[20:0], track_byte[6:0]};
   assign time_sum  = {1'b0, time_accum_ff} + {5'b0, vlv_shift};
   assign time_sat  = time_sum[32] ? 32'hffff_ffff : time_sum[31:0];
   assign meta_dec  = meta_remaining_ff - {27'b0, (meta_remaining_ff != 28'd0)};
   assign cmd       = is_data ? running_status_ff : track_byte;

   always_comb begin
      phase_in            = phase_ff;
      vlv_accum_in        = vlv_accum_ff;
      vlv_count_in        = vlv_count_ff;
      time_accum_in       = time_accum_ff;
      running_status_in   = running_status_ff;
      meta_remaining_in   = meta_remaining_ff;
      held_first_param_in = held_first_param_ff;
      emit                = 1'b0;
      result.delta_ticks  = time_accum_ff;
      result.status_byte  = 8'd0;
      result.data_one     = 8'd0;
      result.data_two     = 8'd0;
      result.parse_error  = ERR_NONE;

      case (phase_ff)
         PH_DELTA, PH_META_LEN: begin
            if (is_data) begin
               vlv_accum_in = 28'd0;
               vlv_count_in = 2'd0;
               if (phase_ff == PH_DELTA) begin
                  time_accum_in = time_sat;
                  phase_in      = PH_STATUS;
               end else begin
                  meta_remaining_in = vlv_shift;
                  phase_in = (vlv_shift == 28'd0) ? PH_DELTA : PH_META_SKIP;
               end
            end else if (vlv_count_ff == VLV_LAST) begin
               emit               = 1'b1;
               result.parse_error = ERR_LONG;
            end else begin
               vlv_accum_in = vlv_shift;
               vlv_count_in = vlv_count_ff + 2'd1;
            end
         end
         PH_STATUS: begin
            if (!is_data) running_status_in = track_byte;
            if (cmd == META_STATUS) begin
               vlv_accum_in = 28'd0;
               vlv_count_in = 2'd0;
               phase_in     = is_data ? PH_META_LEN : PH_META_TYPE;
            end else begin
               case (cmd[7:4])
                  HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CONTROL, HI_BEND: begin
                     if (is_data) begin
                        held_first_param_in = track_byte;
                        phase_in            = PH_P2;
                     end else begin
                        phase_in = PH_P1_OF_TWO;
                     end
                  end
                  HI_PROGRAM, HI_CHAN_AT: begin
                     if (is_data) begin
                        emit               = 1'b1;
                        result.status_byte = cmd;
                        result.data_one    = track_byte;
                     end else begin
                        phase_in = PH_P1_ONLY;
                     end
                  end
                  default: begin
                     running_status_in  = 8'd0;
                     emit               = 1'b1;
                     result.status_byte = cmd;
                     result.parse_error = ERR_STATUS;
                  end
               endcase
            end
         end
         PH_META_TYPE: begin
            vlv_accum_in = 28'd0;
            vlv_count_in = 2'd0;
            phase_in     = PH_META_LEN;
         end
         PH_META_SKIP: begin
            meta_remaining_in = meta_dec;
            if (meta_dec == 28'd0) phase_in = PH_DELTA;
         end
         PH_P1_OF_TWO: begin
            held_first_param_in = track_byte;
            phase_in            = PH_P2;
         end
         PH_P2: begin
            emit               = 1'b1;
            result.status_byte = running_status_ff;
            result.data_one    = held_first_param_ff;
            result.data_two    = track_byte;
         end
         default: begin
            emit               = 1'b1;
            result.status_byte = running_status_ff;
            result.data_one    = track_byte;
         end
      endcase

      // any result restarts the time sum and returns to a delta
      if (emit) begin
         time_accum_in = 32'd0;
         vlv_accum_in  = 28'd0;
         vlv_count_in  = 2'd0;
         phase_in      = PH_DELTA;
      end
   end

   assign result_valid = accept & emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_DELTA;
         vlv_accum_ff        <= 28'd0;
         vlv_count_ff        <= 2'd0;
         time_accum_ff       <= 32'd0;
         running_status_ff   <= 8'd0;
         meta_remaining_ff   <= 28'd0;
         held_first_param_ff <= 8'd0;
      end else if (accept) begin
         phase_ff            <= phase_in;
         vlv_accum_ff        <= vlv_accum_in;
         vlv_count_ff        <= vlv_count_in;
         time_accum_ff       <= time_accum_in;
         running_status_ff   <= running_status_in;
         meta_remaining_ff   <= meta_remaining_in;
         held_first_param_ff <= held_first_param_in;
      end
   end

endmodule

// ===== src/mtep_out_buf.sv =====
// mtep_out_buf: result register plus skid entry, so the input keeps flowing
// depends on mtep_pkg

module mtep_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mtep_pkg::mtep_result_type push_data,
   output logic                      push_ready,
   output logic                      out_valid,
   input  logic                      out_ready,
   output mtep_pkg::mtep_result_type out_data
);
   import mtep_pkg::*;

   logic            out_valid_ff;
   logic            skid_valid_ff;
   mtep_result_type out_data_ff;
   mtep_result_type skid_data_ff;
   logic            pop;

   assign pop        = out_valid_ff & out_ready;
   assign push_ready = ~skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= push;
         if (push) out_data_ff <= push_data;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= push_data;
      end
   end

endmodule

// ===== src/midi_track_event_parser_core.sv =====
// midi track event parser: one track byte per transaction, one result per channel message or error
// output: a result is registered in the output buffer, or in its skid entry, before it shows on rsp_valid
// throughput: one byte per cycle; the only stall comes from the two-entry output buffer
// filling while rsp_ready is low
// reset: synchronous, active high; clears parser state and empties the output buffer
// depends on mtep_pkg, mtep_parser, mtep_out_buf

module midi_track_event_parser_core (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_track_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_delta_ticks,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_data_one,
   output logic [7:0]  rsp_data_two,
   output logic [1:0]  rsp_parse_error
);
   import mtep_pkg::*;

   logic            req_accept;
   logic            result_valid;
   mtep_result_type result;
   mtep_result_type rsp_data;

   // a byte is taken whenever the skid entry is free
   assign req_accept = req_valid & req_ready;

   // whole per-byte update happens in one pass of the parser
   mtep_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .track_byte   (req_track_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   // result register with skid, ready is registered
   mtep_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   // unpack the result transaction onto its ports
   assign rsp_delta_ticks = rsp_data.delta_ticks;
   assign rsp_status_byte = rsp_data.status_byte;
   assign rsp_data_one    = rsp_data.data_one;
   assign rsp_data_two    = rsp_data.data_two;
   assign rsp_parse_error = rsp_data.parse_error;

endmodule

// ===== src/mtep_checker.sv =====
// mtep_checker: port-level assertions for the midi track event parser, with its bind
// depends on mtep_pkg and midi_track_event_parser_core

module mtep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_delta_ticks,
   input logic [7:0]  rsp_status_byte,
   input logic [7:0]  rsp_data_one,
   input logic [7:0]  rsp_data_two,
   input logic [1:0]  rsp_parse_error
);
   import mtep_pkg::*;

   // buffer comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("result pending or input blocked after reset");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_parse_error == ERR_NONE || rsp_parse_error == ERR_STATUS ||
                     rsp_parse_error == ERR_LONG))
      else $error("undefined error code");

   a_long_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parse_error == ERR_LONG) |->
         (rsp_status_byte == 8'd0 && rsp_data_one == 8'd0 && rsp_data_two == 8'd0))
      else $error("long delta result carries message bytes");

   a_status_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parse_error == ERR_STATUS) |->
         (rsp_data_one == 8'd0 && rsp_data_two == 8'd0 && rsp_status_byte[7:4] != 4'h8 &&
          rsp_status_byte != 8'hff))
      else $error("unknown status result malformed");

   // blocked input only while a result is stalled
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input blocked with no pending result");

   logic unused_ok;
   assign unused_ok = ^{req_valid, rsp_ready, rsp_delta_ticks};

endmodule

bind midi_track_event_parser_core mtep_checker u_mtep_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_delta_ticks (rsp_delta_ticks),
   .rsp_status_byte (rsp_status_byte),
   .rsp_data_one    (rsp_data_one),
   .rsp_data_two    (rsp_data_two),
   .rsp_parse_error (rsp_parse_error)
);

// ===== dv/midi_track_event_parser_core_tb.sv =====
// testbench for midi_track_event_parser_core: feeds track bytes, predicts the parsed events
// and checks every result transaction in order; depends on mtep_pkg and the parser rtl only

module midi_track_event_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtep_pkg::*;

   // status and message-type codes of the track format
   localparam logic [7:0] STATUS_META  = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
   localparam logic [3:0] MSG_POLY_AT  = 4'hA;
   localparam logic [3:0] MSG_CONTROL  = 4'hB;
   localparam logic [3:0] MSG_PROGRAM  = 4'hC;
   localparam logic [3:0] MSG_CHAN_AT  = 4'hD;
   localparam logic [3:0] MSG_PITCH    = 4'hE;
   localparam logic [3:0] MSG_SYSTEM   = 4'hF;
   localparam logic [7:0] VLQ_MORE_BIT = 8'h80;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;

   typedef enum logic [2:0] {
      PH_DELTA, PH_STATUS, PH_META_TYPE, PH_META_LEN,
      PH_META_SKIP, PH_FIRST_OF_TWO, PH_SECOND, PH_ONLY_PARAM
   } parse_phase_type;

   typedef enum logic [1:0] {VLQ_MORE, VLQ_DONE, VLQ_OVERLONG} vlq_step_type;

   typedef logic [7:0] byte_seq_type[$];

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_track_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_delta_ticks;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_data_one;
   logic [7:0]  rsp_data_two;
   logic [1:0]  rsp_parse_error;

   midi_track_event_parser_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_track_byte  (req_track_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_delta_ticks (rsp_delta_ticks),
      .rsp_status_byte (rsp_status_byte),
      .rsp_data_one    (rsp_data_one),
      .rsp_data_two    (rsp_data_two),
      .rsp_parse_error (rsp_parse_error)
   );

   // parser state as the testbench sees it
   parse_phase_type parse_phase = PH_DELTA;
   logic [27:0]  vlq_acc     = '0;
   logic [1:0]   vlq_count   = '0;
   logic [31:0]  tick_sum    = '0;
   logic [7:0]   run_status  = '0;
   logic [27:0]  meta_left   = '0;
   logic [7:0]   first_param = '0;

   // parsed events still owed by the block, oldest first
   mtep_result_type expected_events[$];

   int  error_count    = 0;
   int  bytes_accepted = 0;
   int  stall_cycles   = 0;
   int  rsp_hold_len   = 0;
   bit  idle_enable    = 1'b1;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------------------

   // one byte of a variable-length quantity, seven bits per byte, high bit means more
   function automatic vlq_step_type vlq_feed(input logic [7:0] b, output logic [27:0] value);
      value = '0;
      if (!b[7]) begin
         value     = {vlq_acc[20:0], b[6:0]};
         vlq_acc   = '0;
         vlq_count = '0;
         return VLQ_DONE;
      end
      if (vlq_count == 2'd3) return VLQ_OVERLONG;
      vlq_acc   = {vlq_acc[20:0], b[6:0]};
      vlq_count = vlq_count + 2'd1;
      return VLQ_MORE;
   endfunction

   function automatic void add_ticks(input logic [27:0] d);
      logic [32:0] s;
      s        = {1'b0, tick_sum} + {5'b0, d};
      tick_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void push_event(input logic [7:0] st, input logic [7:0] d1,
                                      input logic [7:0] d2, input logic [1:0] err);
      mtep_result_type ev;
      ev.delta_ticks = tick_sum;
      ev.status_byte = st;
      ev.data_one    = d1;
      ev.data_two    = d2;
      ev.parse_error = err;
      expected_events.push_back(ev);
      tick_sum    = '0;
      vlq_acc     = '0;
      vlq_count   = '0;
      parse_phase = PH_DELTA;
   endfunction

   function automatic bit takes_two_params(input logic [7:0] st);
      return st[7:4] inside {MSG_NOTE_OFF, MSG_NOTE_ON, MSG_POLY_AT, MSG_CONTROL, MSG_PITCH};
   endfunction

   function automatic bit takes_one_param(input logic [7:0] st);
      return st[7:4] inside {MSG_PROGRAM, MSG_CHAN_AT};
   endfunction

   function automatic void predict_track_byte(input logic [7:0] b);
      logic [27:0]  value;
      vlq_step_type step;
      logic [7:0]   cmd;
      bit           running;
      case (parse_phase)
         PH_DELTA: begin
            step = vlq_feed(b, value);
            if (step == VLQ_OVERLONG) begin
               push_event('0, '0, '0, ERR_LONG);
            end else if (step == VLQ_DONE) begin
               add_ticks(value);
               parse_phase = PH_STATUS;
            end
         end
         PH_STATUS: begin
            running = !b[7];
            cmd     = running ? run_status : b;
            if (!running) run_status = b;
            if (cmd == STATUS_META) begin
               // under running status the data byte is already the meta type
               vlq_acc     = '0;
               vlq_count   = '0;
               parse_phase = running ? PH_META_LEN : PH_META_TYPE;
            end else if (takes_two_params(cmd)) begin
               if (running) begin
                  first_param = b;
                  parse_phase = PH_SECOND;
               end else begin
                  parse_phase = PH_FIRST_OF_TWO;
               end
            end else if (takes_one_param(cmd)) begin
               if (running) push_event(cmd, b, '0, ERR_NONE);
               else parse_phase = PH_ONLY_PARAM;
            end else begin
               // system status or no stored status: flag it and forget the status
               run_status = '0;
               push_event(cmd, '0, '0, ERR_STATUS);
            end
         end
         PH_META_TYPE: begin
            vlq_acc     = '0;
            vlq_count   = '0;
            parse_phase = PH_META_LEN;
         end
         PH_META_LEN: begin
            step = vlq_feed(b, value);
            if (step == VLQ_OVERLONG) begin
               push_event('0, '0, '0, ERR_LONG);
            end else if (step == VLQ_DONE) begin
               meta_left   = value;
               parse_phase = (value == '0) ? PH_DELTA : PH_META_SKIP;
            end
         end
         PH_META_SKIP: begin
            if (meta_left != '0) meta_left = meta_left - 28'd1;
            if (meta_left == '0) parse_phase = PH_DELTA;
         end
         PH_FIRST_OF_TWO: begin
            first_param = b;
            parse_phase = PH_SECOND;
         end
         PH_SECOND: push_event(run_status, first_param, b, ERR_NONE);
         default:   push_event(run_status, b, '0, ERR_NONE);
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // outputs are sampled at the rising edge, before the block updates them
   always @(posedge clock) begin : result_checker
      mtep_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected result status_byte", 32'(rsp_status_byte), 32'd0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_delta_ticks !== want.delta_ticks)
               report_mismatch("delta_ticks", rsp_delta_ticks, want.delta_ticks);
            if (rsp_status_byte !== want.status_byte)
               report_mismatch("status_byte", 32'(rsp_status_byte), 32'(want.status_byte));
            if (rsp_data_one !== want.data_one)
               report_mismatch("data_one", 32'(rsp_data_one), 32'(want.data_one));
            if (rsp_data_two !== want.data_two)
               report_mismatch("data_two", 32'(rsp_data_two), 32'(want.data_two));
            if (rsp_parse_error !== want.parse_error)
               report_mismatch("parse_error", 32'(rsp_parse_error), 32'(want.parse_error));
         end
      end
   end

   // watchdog: any transaction on either channel resets the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // result side: random stall bursts, or a long counted hold when a test asks for one
   // ---------------------------------------------------------------------------------------

   initial begin : rsp_side
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            n            = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_ready   <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            n          = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // byte side
   // ---------------------------------------------------------------------------------------

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap             = $urandom_range(1, 16);
         req_valid      <= 1'b0;
         req_track_byte <= 8'($urandom_range(0, 255));
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_track_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_track_byte(b);
      bytes_accepted++;
      @(negedge clock);
   endtask

   task automatic send_seq(input byte_seq_type s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_data7();
      return 8'($urandom_range(0, 127));
   endfunction

   // parameters are mostly proper data bytes, now and then any value at all
   function automatic logic [7:0] rand_param();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : rand_data7();
   endfunction

   function automatic logic [7:0] rand_channel_status();
      logic [3:0] kinds[7];
      kinds = '{MSG_NOTE_OFF, MSG_NOTE_ON, MSG_POLY_AT, MSG_CONTROL,
                MSG_PROGRAM, MSG_CHAN_AT, MSG_PITCH};
      return {kinds[$urandom_range(0, 6)], 4'($urandom_range(0, 15))};
   endfunction

   // delta time of one to four bytes, mostly short
   task automatic send_delta();
      int r;
      int n;
      r = $urandom_range(0, 15);
      n = (r < 10) ? 1 : (r < 13) ? 2 : (r < 15) ? 3 : 4;
      repeat (n - 1) send_byte(VLQ_MORE_BIT | rand_data7());
      send_byte(rand_data7());
   endtask

   // meta length and body, the type byte already sent
   task automatic send_meta_body();
      int len;
      if ($urandom_range(0, 19) == 0) begin
         len = 128 + $urandom_range(0, 16);
         send_byte(VLQ_MORE_BIT | 8'd1);
         send_byte(8'(len - 128));
      end else begin
         len = $urandom_range(0, 5);
         send_byte(8'(len));
      end
      repeat (len) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_channel_params(input logic [7:0] st);
      send_byte(rand_param());
      if (takes_two_params(st)) send_byte(rand_param());
   endtask

   // one event, mostly well formed, sometimes broken or pure noise
   task automatic send_random_event();
      int          kind;
      logic [7:0]  st;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         st = rand_channel_status();
         send_delta();
         send_byte(st);
         send_channel_params(st);
      end else if (kind < 65) begin
         // running status: meta, channel message, or none stored
         send_delta();
         if (run_status == STATUS_META) begin
            send_byte(rand_data7());
            send_meta_body();
         end else if (takes_two_params(run_status)) begin
            send_byte(rand_data7());
            send_byte(rand_param());
         end else begin
            send_byte(rand_data7());
         end
      end else if (kind < 80) begin
         send_delta();
         send_byte(STATUS_META);
         send_byte(8'($urandom_range(0, 255)));
         send_meta_body();
      end else if (kind < 87) begin
         send_delta();
         send_byte({MSG_SYSTEM, 4'($urandom_range(0, 14))});
      end else if (kind < 92) begin
         repeat (4) send_byte(VLQ_MORE_BIT | 8'($urandom_range(0, 127)));
      end else if (kind < 96) begin
         send_delta();
         send_byte(STATUS_META);
         send_byte(rand_data7());
         repeat (4) send_byte(VLQ_MORE_BIT | 8'($urandom_range(0, 127)));
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // every message type, running status, parameters at both extremes
   task automatic test_channel_messages();
      byte_seq_type seq;
      // data byte straight after reset: no stored status yet
      seq = '{8'h00, 8'h05};
      send_seq(seq);
      seq = '{8'h00, {MSG_NOTE_ON, 4'h0}, 8'h3C, 8'h7F,
              8'h05, 8'h40, 8'h00,
              8'h7F, {MSG_NOTE_OFF, 4'hF}, 8'h00, 8'h00,
              8'h00, {MSG_POLY_AT, 4'h3}, 8'h80, 8'hFF,
              8'h00, {MSG_CONTROL, 4'h7}, 8'h07, 8'h64,
              8'h00, {MSG_PROGRAM, 4'h3}, 8'h85,
              8'h10, 8'h22,
              8'h00, {MSG_CHAN_AT, 4'h1}, 8'hFF,
              8'h00, {MSG_PITCH, 4'h0}, 8'hFF, 8'h80,
              8'h01, 8'h7F, 8'h7F};
      send_seq(seq);
   endtask

   // unknown status, over-long delta, meta skipping and meta under running status
   task automatic test_special_cases();
      byte_seq_type seq;
      seq = '{8'h00, STATUS_SYSEX, 8'h00, {MSG_SYSTEM, 4'hE},
              8'h80, 8'h80, 8'h80, 8'h80,
              8'hFF, 8'hFF, 8'hFF, 8'h7F, {MSG_NOTE_ON, 4'h2}, 8'h30, 8'h40,
              8'h10, STATUS_META, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
              8'h81, 8'h00, {MSG_NOTE_ON, 4'h0}, 8'h40, 8'h40,
              8'h00, STATUS_META, 8'h2F, 8'h00,
              8'h03, 8'h06, 8'h00,
              8'h04, 8'h05, 8'h01, 8'h41,
              8'h81, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80,
              8'h00, STATUS_META, 8'h01, 8'h80, 8'h80, 8'h80, 8'h80,
              8'h00, {MSG_NOTE_OFF, 4'h5}, 8'h40, 8'h00};
      send_seq(seq);
   endtask

   // enough maximal deltas through zero-length metas to saturate the tick sum
   task automatic test_time_saturation();
      byte_seq_type seq;
      seq = '{8'h00, STATUS_META, 8'h21, 8'h00};
      send_seq(seq);
      repeat (17) begin
         seq = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h01, 8'h00};
         send_seq(seq);
      end
      seq = '{8'h00, {MSG_NOTE_ON, 4'h0}, 8'h40, 8'h40, 8'h00, 8'h40, 8'h00};
      send_seq(seq);
   endtask

   task automatic test_random_events(input int n_bytes);
      int stop_at;
      stop_at = bytes_accepted + n_bytes;
      while (bytes_accepted < stop_at) send_random_event();
   endtask

   // result side held off for a long stretch while notes keep coming, so the input stalls
   task automatic test_output_backpressure();
      idle_enable  = 1'b0;
      rsp_hold_len = LONG_HOLD;
      repeat (40) begin
         send_delta();
         send_byte({MSG_NOTE_ON, 4'($urandom_range(0, 15))});
         send_byte(rand_data7());
         send_byte(rand_data7());
      end
      idle_enable = 1'b1;
   endtask

   // closing stretch with both sides running flat out
   task automatic test_streaming();
      idle_enable = 1'b0;
      test_random_events(250);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_track_byte = 8'h00;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_channel_messages();
      test_special_cases();
      test_time_saturation();
      test_random_events(600);
      test_output_backpressure();
      test_streaming();

      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      // a result is registered in the output buffer after its last byte; allow a little more
      repeat (8) @(posedge clock);
      if (expected_events.size() != 0)
         report_mismatch("results left outstanding", 32'(expected_events.size()), 32'd0);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== midi_track_event_parser_core.f =====
src/mtep_pkg.sv
src/mtep_parser.sv
src/mtep_out_buf.sv
src/midi_track_event_parser_core.sv
src/mtep_checker.sv
dv/midi_track_event_parser_core_tb.sv
